// ----- rtl/i2c_master_transfer_sequencer_core_assert.svh -----
// Assertion macros for the transfer sequencer.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define I2CMTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cmts: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define I2CMTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cmts: next-cycle check failed");
`else
`define I2CMTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define I2CMTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/i2cmts_pkg.sv -----
`default_nettype none
package i2cmts_pkg;

  localparam int BUF_DEPTH_DEF = 256;
  localparam int IDX_W = 9;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_WRITE = 2'd1,
    FN_READ  = 2'd2,
    FN_EVENT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TX   = 2'd1,
    MODE_RX   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ACK_KEEP   = 2'd0,
    ACK_NACK   = 2'd1,
    ACK_ENABLE = 2'd2
  } ack_t;

  typedef enum logic [1:0] {
    DONE_NONE  = 2'd0,
    DONE_WRITE = 2'd1,
    DONE_READ  = 2'd2,
    DONE_ERROR = 2'd3
  } done_t;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] slave_address;
    logic [8:0] length;
    logic [7:0] load_index;
    logic [7:0] data_byte;
    logic       start_bit;
    logic       address_sent;
    logic       tx_empty;
    logic       rx_not_empty;
    logic       ack_failure;
    logic       bus_error;
    logic       arbitration_lost;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       start_request;
    logic       write_valid;
    logic [7:0] write_data;
    logic       stop_request;
    logic [1:0] ack_control;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] rx_byte;
    logic [1:0] done_kind;
    logic [2:0] error_bits;
    logic       busy_res;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/i2cmts_if.sv -----
`default_nettype none
interface i2cmts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] slave_address;
  logic [8:0] length;
  logic [7:0] load_index;
  logic [7:0] data_byte;
  logic       start_bit;
  logic       address_sent;
  logic       tx_empty;
  logic       rx_not_empty;
  logic       ack_failure;
  logic       bus_error;
  logic       arbitration_lost;

  modport source (
    output valid, func, slave_address, length, load_index, data_byte, start_bit,
           address_sent, tx_empty, rx_not_empty, ack_failure, bus_error, arbitration_lost,
    input  ready
  );
  modport sink (
    input  valid, func, slave_address, length, load_index, data_byte, start_bit,
           address_sent, tx_empty, rx_not_empty, ack_failure, bus_error, arbitration_lost,
    output ready
  );
endinterface

interface i2cmts_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       start_request;
  logic       write_valid;
  logic [7:0] write_data;
  logic       stop_request;
  logic [1:0] ack_control;
  logic       rx_valid;
  logic [7:0] rx_index;
  logic [7:0] rx_byte;
  logic [1:0] done_kind;
  logic [2:0] error_bits;
  logic       busy_res;

  modport source (
    output valid, accepted, start_request, write_valid, write_data, stop_request,
           ack_control, rx_valid, rx_index, rx_byte, done_kind, error_bits, busy_res,
    input  ready
  );
  modport sink (
    input  valid, accepted, start_request, write_valid, write_data, stop_request,
           ack_control, rx_valid, rx_index, rx_byte, done_kind, error_bits, busy_res,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/i2cmts_ctrl.sv -----
`default_nettype none
module i2cmts_ctrl
  import i2cmts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  // Take an item only while idle; execute once the result register is free
  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;

  // Hold state and result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.capture) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd.exec) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/i2cmts_dp.sv -----
`default_nettype none
module i2cmts_dp
  import i2cmts_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cmd,
  input  wire in_item_t in_item,
  output out_item_t out_item
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [31:0] DEPTH_W = 32'(BUF_DEPTH);

  // Transfer buffer, one write and one registered read port
  logic [7:0] tbuf_mem [BUF_DEPTH];
  logic [7:0] rd_data_r;
  logic       mem_we;
  logic [7:0] mem_wdata;
  logic [31:0] wr_idx_w;
  logic [31:0] rd_idx_w;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  in_item_t       item_r;
  out_item_t      out_r;
  out_item_t      res;
  mode_t          mode_r, mode_nxt;
  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [IDX_W-1:0] byte_count_r, byte_count_nxt;
  logic [6:0]     target_r, target_nxt;
  logic [2:0]     errs;
  logic [IDX_W-1:0] idx_inc;

  assign errs    = {item_r.arbitration_lost, item_r.bus_error, item_r.ack_failure};
  assign idx_inc = byte_index_r + 1'b1;
  assign rd_idx_w = 32'(byte_index_r);
  assign rd_addr  = rd_idx_w[AW-1:0];
  assign wr_addr  = wr_idx_w[AW-1:0];
  assign out_item = out_r;

  // Work out the result and next state of the held item
  always_comb begin
    res            = '0;
    mode_nxt       = mode_r;
    byte_index_nxt = byte_index_r;
    byte_count_nxt = byte_count_r;
    target_nxt     = target_r;
    mem_we         = 1'b0;
    mem_wdata      = item_r.data_byte;
    wr_idx_w       = 32'(item_r.load_index);
    case (func_t'(item_r.func))
      FN_LOAD: begin
        if (mode_r == MODE_IDLE && 32'(item_r.load_index) < DEPTH_W) begin
          mem_we       = 1'b1;
          res.accepted = 1'b1;
        end
      end
      FN_WRITE, FN_READ: begin
        if (mode_r == MODE_IDLE && item_r.length != '0 &&
            32'(item_r.length) <= DEPTH_W) begin
          mode_nxt          = (func_t'(item_r.func) == FN_WRITE) ? MODE_TX : MODE_RX;
          byte_index_nxt    = '0;
          byte_count_nxt    = item_r.length;
          target_nxt        = item_r.slave_address;
          res.accepted      = 1'b1;
          res.start_request = 1'b1;
        end
      end
      FN_EVENT: begin
        if (errs != 3'b000) begin
          // Abort and release the bus
          res.stop_request = 1'b1;
          res.done_kind    = DONE_ERROR;
          res.error_bits   = errs;
          mode_nxt         = MODE_IDLE;
        end else if (item_r.start_bit) begin
          if (mode_r == MODE_TX || mode_r == MODE_RX) begin
            res.write_valid = 1'b1;
            res.write_data  = {target_r, (mode_r == MODE_RX)};
          end
        end else if (item_r.address_sent) begin
          if (mode_r == MODE_RX && byte_count_r == IDX_W'(1)) res.ack_control = ACK_NACK;
        end else if (mode_r == MODE_TX && item_r.tx_empty) begin
          if (byte_index_r < byte_count_r && 32'(byte_index_r) < DEPTH_W) begin
            res.write_valid = 1'b1;
            res.write_data  = rd_data_r;
            byte_index_nxt  = idx_inc;
          end else begin
            res.stop_request = 1'b1;
            res.done_kind    = DONE_WRITE;
            mode_nxt         = MODE_IDLE;
          end
        end else if (mode_r == MODE_RX && item_r.rx_not_empty) begin
          // Store the received byte and step the index
          if (32'(byte_index_r) < DEPTH_W) begin
            mem_we   = 1'b1;
            wr_idx_w = 32'(byte_index_r);
          end
          res.rx_valid   = 1'b1;
          res.rx_index   = byte_index_r[7:0];
          res.rx_byte    = item_r.data_byte;
          byte_index_nxt = idx_inc;
          if (idx_inc >= byte_count_r) begin
            res.stop_request = 1'b1;
            res.ack_control  = ACK_ENABLE;
            res.done_kind    = DONE_READ;
            mode_nxt         = MODE_IDLE;
          end else if ({1'b0, idx_inc} + 1'b1 == {1'b0, byte_count_r}) begin
            res.ack_control = ACK_NACK;
          end
        end
      end
      default: ;
    endcase
    res.busy_res = (mode_nxt != MODE_IDLE);
  end

  // Buffer write and registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) tbuf_mem[wr_addr] <= mem_wdata;
    if (cmd.capture) rd_data_r <= tbuf_mem[rd_addr];
  end

  // Hold the item and the result
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    if (cmd.exec) out_r <= res;
  end

  // Transfer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      byte_index_r <= '0;
      byte_count_r <= '0;
      target_r     <= '0;
    end else if (cmd.exec) begin
      mode_r       <= mode_nxt;
      byte_index_r <= byte_index_nxt;
      byte_count_r <= byte_count_nxt;
      target_r     <= target_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/i2c_master_transfer_sequencer_core.sv -----
// An accepted item is captured, then executed into the result register once that register is free.
// Only one item is in flight: no new item is taken until the held one has executed;
// the registered read of the transfer buffer memory sits between capture and execution.
// A stalled result holds until taken; the next item can be accepted meanwhile.
// Reset (rst_n low, synchronous): idle mode, index, count and address cleared;
// buffer contents are not cleared.
`default_nettype none
`include "i2c_master_transfer_sequencer_core_assert.svh"
module i2c_master_transfer_sequencer_core
  import i2cmts_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  i2cmts_in_if.sink     in_ch,
  i2cmts_out_if.source  out_ch
);

  cmd_t      cmd;
  in_item_t  in_item;
  out_item_t out_item;

  // Pack the input payload
  assign in_item = '{
    func:             in_ch.func,
    slave_address:    in_ch.slave_address,
    length:           in_ch.length,
    load_index:       in_ch.load_index,
    data_byte:        in_ch.data_byte,
    start_bit:        in_ch.start_bit,
    address_sent:     in_ch.address_sent,
    tx_empty:         in_ch.tx_empty,
    rx_not_empty:     in_ch.rx_not_empty,
    ack_failure:      in_ch.ack_failure,
    bus_error:        in_ch.bus_error,
    arbitration_lost: in_ch.arbitration_lost
  };

  i2cmts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  i2cmts_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // Unpack the result payload
  assign out_ch.accepted      = out_item.accepted;
  assign out_ch.start_request = out_item.start_request;
  assign out_ch.write_valid   = out_item.write_valid;
  assign out_ch.write_data    = out_item.write_data;
  assign out_ch.stop_request  = out_item.stop_request;
  assign out_ch.ack_control   = out_item.ack_control;
  assign out_ch.rx_valid      = out_item.rx_valid;
  assign out_ch.rx_index      = out_item.rx_index;
  assign out_ch.rx_byte       = out_item.rx_byte;
  assign out_ch.done_kind     = out_item.done_kind;
  assign out_ch.error_bits    = out_item.error_bits;
  assign out_ch.busy_res      = out_item.busy_res;

  // One item in flight: no accept right after an accept
  `I2CMTS_ASSERT_NXT(a_one_in_flight, clk, rst_n, cmd.capture, !in_ch.ready)
  // A finished or aborted transfer leaves the block idle
  `I2CMTS_ASSERT_IMP(a_done_idle, clk, rst_n, out_ch.valid && out_ch.done_kind != DONE_NONE, !out_ch.busy_res)
  // A start request only comes with an accepted start that leaves a transfer running
  `I2CMTS_ASSERT_IMP(a_start_busy, clk, rst_n, out_ch.valid && out_ch.start_request, out_ch.accepted && out_ch.busy_res)
  // Execution always lands in the result register
  `I2CMTS_ASSERT_NXT(a_exec_out, clk, rst_n, cmd.exec, out_ch.valid)

endmodule
`default_nettype wire
